/* src/assert_macros.svh */
// Assertion helpers for the RTL files; only the datapath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, also during reset.
`define OHFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only out of reset.
`define OHFM_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* src/ohfm_pkg.sv */
package ohfm_pkg;

  localparam int HITS_PER_ORBIT_DEF = 64;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_ORBIT = 2'd1;
  localparam logic [1:0] ACT_MERGE = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [21:0] BC_WRAP = 22'h100000;
  localparam logic [22:0] MAX_GAP = 23'd8;
  localparam logic [23:0] ADC_MAX = 24'hFFFFFF;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_WORD_W = 129;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_ARD,
    ST_M_ACHK,
    ST_M_BRD,
    ST_M_BCMP,
    ST_S_CHK,
    ST_F_RD,
    ST_F_CHK,
    ST_F_PUSH,
    ST_F_END
  } state_t;

  typedef struct packed {
    logic latch;
    logic add_wr;
    logic rd_en;
    logic load_a;
    logic merge_wr;
    logic pend_load;
    logic push;
    logic push_last;
    logic swap;
  } cmd_t;

  typedef struct packed {
    logic cur_sel;
    logic a_zero;
    logic merge_ok;
    logic emit_ok;
    logic pend_valid;
    logic out_free;
    logic same_orbit;
    logic cross_skip;
  } status_t;

endpackage

/* src/ohfm_ctrl.sv */
module ohfm_ctrl #(
  parameter int HITS_PER_ORBIT = ohfm_pkg::HITS_PER_ORBIT_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [1:0]                              in_action,
  input  ohfm_pkg::status_t                       st,
  input  logic [$clog2(HITS_PER_ORBIT+1)-1:0]     np,
  input  logic [$clog2(HITS_PER_ORBIT+1)-1:0]     nc,
  output ohfm_pkg::cmd_t                          cmd,
  output logic [$clog2(HITS_PER_ORBIT):0]         rd_addr
);
  import ohfm_pkg::*;

  localparam int FW = $clog2(HITS_PER_ORBIT + 1);
  localparam int IW = $clog2(HITS_PER_ORBIT);

  state_t          state_r, state_nxt;
  logic [FW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic            phase_r, phase_nxt;   // 0: previous within itself, 1: current into previous
  logic [FW-1:0]   lim_i;
  logic            cur, prv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    cur       = st.cur_sel;
    prv       = ~st.cur_sel;
    lim_i     = phase_r ? nc : np;
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    phase_nxt = phase_r;
    cmd       = '0;
    rd_addr   = '0;
    in_tready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          unique case (in_action)
            ACT_ADD:   cmd.add_wr = 1'b1;
            ACT_ORBIT: state_nxt = ST_S_CHK;
            ACT_MERGE: begin
              i_nxt     = '0;
              phase_nxt = 1'b0;
              state_nxt = ST_M_ARD;
            end
            default: ;
          endcase
        end
      end
      ST_M_ARD: begin
        if (i_r == lim_i) begin
          if (!phase_r && !st.cross_skip) begin
            phase_nxt = 1'b1;
            i_nxt     = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = {(phase_r ? cur : prv), i_r[IW-1:0]};
          state_nxt = ST_M_ACHK;
        end
      end
      ST_M_ACHK: begin
        cmd.load_a = 1'b1;
        if (st.a_zero) begin
          j_nxt     = '0;
          state_nxt = ST_M_BRD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_M_ARD;
        end
      end
      ST_M_BRD: begin
        if (j_r == np) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_M_ARD;
        end else if (!phase_r && j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = {prv, j_r[IW-1:0]};
          state_nxt = ST_M_BCMP;
        end
      end
      ST_M_BCMP: begin
        if (st.merge_ok) begin
          cmd.merge_wr = 1'b1;
          i_nxt        = i_r + 1'b1;
          state_nxt    = ST_M_ARD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_M_BRD;
        end
      end
      ST_S_CHK: begin
        i_nxt     = '0;
        state_nxt = st.same_orbit ? ST_IDLE : ST_F_RD;
      end
      ST_F_RD: begin
        if (i_r == np) begin
          state_nxt = ST_F_END;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = {prv, i_r[IW-1:0]};
          state_nxt = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        if (st.emit_ok && st.pend_valid) begin
          state_nxt = ST_F_PUSH;
        end else begin
          cmd.pend_load = st.emit_ok;
          i_nxt         = i_r + 1'b1;
          state_nxt     = ST_F_RD;
        end
      end
      ST_F_PUSH: begin
        // held word goes out, the one just read takes its place
        if (st.out_free) begin
          cmd.push      = 1'b1;
          cmd.pend_load = 1'b1;
          i_nxt         = i_r + 1'b1;
          state_nxt     = ST_F_RD;
        end
      end
      ST_F_END: begin
        if (!st.pend_valid) begin
          cmd.swap  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (st.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          cmd.swap      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/ohfm_dp.sv */
module ohfm_dp #(
  parameter int HITS_PER_ORBIT = ohfm_pkg::HITS_PER_ORBIT_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [ohfm_pkg::IN_DATA_W-1:0]          in_tdata,
  input  ohfm_pkg::cmd_t                          cmd,
  input  logic [$clog2(HITS_PER_ORBIT):0]         rd_addr,
  output ohfm_pkg::status_t                       st,
  output logic [$clog2(HITS_PER_ORBIT+1)-1:0]     np,
  output logic [$clog2(HITS_PER_ORBIT+1)-1:0]     nc,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [ohfm_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                    out_tlast
);
  import ohfm_pkg::*;
  `include "assert_macros.svh"

  localparam int FW    = $clog2(HITS_PER_ORBIT + 1);
  localparam int IW    = $clog2(HITS_PER_ORBIT);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 * (1 << IW);
  localparam logic [FW-1:0] FILL_MAX = FW'(HITS_PER_ORBIT);

  logic [49:0] key_mem   [DEPTH];
  logic [23:0] adc_mem   [DEPTH];
  logic [29:0] start_mem [DEPTH];
  logic [29:0] stop_mem  [DEPTH];
  logic [31:0] orbit_mem [DEPTH];
  logic        mark_mem  [DEPTH];

  logic [49:0] rd_key_r;
  logic [23:0] rd_adc_r;
  logic [29:0] rd_start_r, rd_stop_r;
  logic [31:0] rd_orbit_r;
  logic        rd_mark_r;
  logic [AW-1:0] rd_addr_r;

  logic [49:0] a_key_r;
  logic [23:0] a_adc_r;
  logic [29:0] a_start_r, a_stop_r;
  logic        a_mark_r;
  logic [AW-1:0] a_addr_r;

  logic [FW-1:0] fill_r [2];
  logic [31:0]   orb_r  [2];
  logic          cur_sel_r;
  logic [31:0]   orbit_r;
  logic          stop_r;

  logic [OUT_WORD_W-1:0] pend_r, out_word_r, emit_word;
  logic                  pend_valid_r, out_valid_r, out_last_r;

  logic          cur, prv, add_ok;
  logic [AW-1:0] add_addr;
  logic [21:0]   bx_start, t_start, t_stop;
  logic [22:0]   gap;
  logic [24:0]   adc_sum;
  logic [23:0]   adc_sat;
  logic [20:0]   ft_start, ft_stop, ft_diff;
  logic [15:0]   size;
  logic [31:0]   orb_diff;

  assign cur      = cur_sel_r;
  assign prv      = ~cur_sel_r;
  assign np       = fill_r[prv];
  assign nc       = fill_r[cur];
  assign add_ok   = cmd.add_wr && (fill_r[cur] < FILL_MAX);
  assign add_addr = {cur, fill_r[cur][IW-1:0]};

  // join check: later fragment a (held) against earlier fragment b (just read)
  always_comb begin
    bx_start = {2'b0, a_start_r[19:0]} +
               ((a_start_r[19:0] < rd_stop_r[19:0]) ? BC_WRAP : 22'd0);
    t_start  = bx_start + {10'b0, a_start_r[29:20], 2'b0};
    t_stop   = {2'b0, rd_stop_r[19:0]} + {10'b0, rd_stop_r[29:20], 2'b0};
    gap      = {1'b0, t_start} - {1'b0, t_stop};
    adc_sum  = {1'b0, a_adc_r} + {1'b0, rd_adc_r};
    adc_sat  = adc_sum[24] ? ADC_MAX : adc_sum[23:0];
    ft_start = {1'b0, rd_start_r[19:0]} + {9'b0, rd_start_r[29:20], 2'b0};
    ft_stop  = {1'b0, rd_stop_r[19:0]} + {9'b0, rd_stop_r[29:20], 2'b0};
    ft_diff  = ft_stop - ft_start;
    size     = ft_diff[17:2] + 16'd1;
    orb_diff = orb_r[cur] - orb_r[prv];
    emit_word = {size, rd_orbit_r, rd_start_r[29:20], rd_start_r[19:0], rd_adc_r,
                 rd_key_r[48:34], rd_key_r[33:22]};
  end

  always_comb begin
    st            = '0;
    st.cur_sel    = cur_sel_r;
    st.a_zero     = (rd_start_r[29:20] == 10'd0);
    st.merge_ok   = !a_mark_r && !rd_mark_r && (a_key_r == rd_key_r) &&
                    !gap[22] && (gap <= MAX_GAP);
    st.emit_ok    = !rd_mark_r && !rd_key_r[49];
    st.pend_valid = pend_valid_r;
    st.out_free   = !out_valid_r || out_tready;
    st.same_orbit = (orbit_r == orb_r[cur]) && !stop_r;
    st.cross_skip = (orb_r[cur] >= orb_r[prv]) && (orb_diff > 32'd1);
  end

  // hit stores
  always_ff @(posedge clk) begin
    if (add_ok) begin
      key_mem[add_addr]   <= in_tdata[49:0];
      start_mem[add_addr] <= in_tdata[103:74];
      orbit_mem[add_addr] <= in_tdata[165:134];
    end
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      adc_mem[add_addr]  <= in_tdata[73:50];
      stop_mem[add_addr] <= in_tdata[133:104];
    end else if (cmd.merge_wr) begin
      adc_mem[rd_addr_r]  <= adc_sat;
      stop_mem[rd_addr_r] <= a_stop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      mark_mem[add_addr] <= 1'b0;
    end else if (cmd.merge_wr) begin
      mark_mem[a_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_key_r   <= key_mem[rd_addr];
      rd_adc_r   <= adc_mem[rd_addr];
      rd_start_r <= start_mem[rd_addr];
      rd_stop_r  <= stop_mem[rd_addr];
      rd_orbit_r <= orbit_mem[rd_addr];
      rd_mark_r  <= mark_mem[rd_addr];
      rd_addr_r  <= rd_addr;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_key_r   <= rd_key_r;
      a_adc_r   <= rd_adc_r;
      a_start_r <= rd_start_r;
      a_stop_r  <= rd_stop_r;
      a_mark_r  <= rd_mark_r;
      a_addr_r  <= rd_addr_r;
    end
    if (cmd.latch) begin
      orbit_r <= in_tdata[165:134];
      stop_r  <= in_tdata[166];
    end
    if (cmd.pend_load) begin
      pend_r <= emit_word;
    end
    if (cmd.push) begin
      out_word_r <= pend_r;
      out_last_r <= cmd.push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r[0]    <= '0;
      fill_r[1]    <= '0;
      orb_r[0]     <= '0;
      orb_r[1]     <= '0;
      cur_sel_r    <= 1'b1;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (add_ok) begin
        fill_r[cur] <= fill_r[cur] + 1'b1;
      end
      if (cmd.swap) begin
        cur_sel_r   <= prv;
        fill_r[prv] <= '0;
        orb_r[prv]  <= orbit_r;
      end
      if (cmd.pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.push) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_WORD_W){1'b0}}, out_word_r};

  `OHFM_ASSERT_RUN(a_fill_bound, fill_r[0] <= FILL_MAX && fill_r[1] <= FILL_MAX, "fill overflow")
  `OHFM_ASSERT_RUN(a_swap_flips, cmd.swap |=> cur_sel_r != $past(cur_sel_r), "no buffer swap")
  `OHFM_ASSERT_RUN(a_push_pending, cmd.push |-> pend_valid_r, "push without a held word")
  `OHFM_ASSERT_ALWAYS(a_no_merge_on_add, !(cmd.merge_wr && cmd.add_wr), "merge write during add")

endmodule

/* src/orbit_hit_fragment_merger.sv */
// Add item: one add per cycle back to back.
// Merge item: accepted, then each hit of a scanned buffer is read; for hits that start at
//   sample 0 each candidate pair is read and compared, the self pair is skipped, and the scan
//   moves on when no join is found (one read port on the hit stores sets the pace).
// Set-orbit flush: accept and check, then read and check each stored hit of the previous buffer,
//   push each emitted hit after the first, and end; the output can stall the flush. The last word
//   leaves from the output register after the block goes idle. Same orbit, no stop flag: no flush.
// Reset (rst_n low, synchronous): both buffers empty, orbits zero, buffer 1 current.
module orbit_hit_fragment_merger #(
  parameter int HITS_PER_ORBIT = ohfm_pkg::HITS_PER_ORBIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action[1:0]
  input  logic [1:0]                        in_tuser,
  // elec_channel[21:0] det_elem[33:22] pad_id[49:34] adc[73:50] start_bc[93:74]
  // start_sample[103:94] stop_bc[123:104] stop_sample[133:124] orbit[165:134]
  // stop_flag[166]
  input  logic [ohfm_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_det_elem[11:0] out_pad_id[26:12] out_adc[50:27] out_start_bc[70:51]
  // out_start_sample[80:71] out_orbit[112:81] out_size[128:113]
  output logic [ohfm_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import ohfm_pkg::*;

  localparam int FW = $clog2(HITS_PER_ORBIT + 1);
  localparam int AW = $clog2(HITS_PER_ORBIT) + 1;

  cmd_t          cmd;
  status_t       st;
  logic [AW-1:0] rd_addr;
  logic [FW-1:0] np, nc;

  ohfm_ctrl #(.HITS_PER_ORBIT(HITS_PER_ORBIT)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .st        (st),
    .np        (np),
    .nc        (nc),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  ohfm_dp #(.HITS_PER_ORBIT(HITS_PER_ORBIT)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .st         (st),
    .np         (np),
    .nc         (nc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
